// ===== hdl/fcne_pkg.sv =====
// fcne_pkg: shared types and constants for the front coded name encoder
// result beat layout, result kinds, register map and parameter defaults
// no dependencies
package fcne_pkg;

	localparam int DEF_MAX_NAME_LEN      = 255;
	localparam int DEF_BYTES_PER_RESULT  = 8;
	localparam int NAME_ALIGN            = 8;
	localparam int ALIGN_W               = $clog2(NAME_ALIGN);
	localparam logic [7:0] DEF_RESTART_EVERY = 8'd16;

	localparam int APB_ADDR_W = 1;
	localparam logic [APB_ADDR_W-1:0] REG_RESTART_EVERY = 1'b0;

	typedef enum logic [1:0] {
		KIND_ADDR    = 2'd0,
		KIND_RESTART = 2'd1,
		KIND_NAME    = 2'd2,
		KIND_TOTAL   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [63:0] payload;
		logic [3:0]  byte_count;
		logic        name_too_long;
		logic        run_last;
	} beat_t;

endpackage

// ===== hdl/fcne_ram.sv =====
// fcne_ram: generic simple dual port ram, one write and one read port
// read data is registered; no reset on the storage
// no dependencies
module fcne_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/fcne_seq.sv =====
// fcne_seq: sequencer of the front coded name encoder
// stores names in two ram banks, tracks the shared prefix, builds result beats
// depends on fcne_pkg and fcne_ram
module fcne_seq #(
	parameter int MAX_NAME_LEN     = fcne_pkg::DEF_MAX_NAME_LEN,
	parameter int BYTES_PER_RESULT = fcne_pkg::DEF_BYTES_PER_RESULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        restart_every,
	input  logic              in_valid,
	output logic              busy,
	input  logic              mode,
	input  logic [7:0]        name_char,
	input  logic              name_end,
	input  logic [31:0]       sym_offset,
	input  logic [31:0]       sym_size,
	output logic              out_valid,
	input  logic              out_stall,
	output fcne_pkg::beat_t   out_beat
);

	localparam int IW = $clog2(MAX_NAME_LEN);
	localparam int LW = $clog2(MAX_NAME_LEN + 1);
	localparam int RW = LW + 1;
	localparam int CW = (BYTES_PER_RESULT > 1) ? $clog2(BYTES_PER_RESULT) : 1;
	localparam int AW = fcne_pkg::ALIGN_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP,
		S_ADDR,
		S_RST,
		S_GATHER,
		S_WAIT,
		S_EMIT,
		S_TOTAL
	} state_t;

	state_t          state_q;
	logic            bank_q;
	logic [LW-1:0]   cur_len_q;
	logic [LW-1:0]   prev_len_q;
	logic [LW-1:0]   shared_q;
	logic            match_q;
	logic            ovf_q;
	logic [31:0]     sym_cnt_q;
	logic [31:0]     nsb_q;
	logic [7:0]      phase_q;
	logic [LW-1:0]   she_q;
	logic [RW-1:0]   rec_len_q;
	logic [RW-1:0]   pos_q;
	logic [CW-1:0]   cnt_q;
	logic [3:0]      ecnt_q;
	logic            last_chunk_q;
	logic            pad_mode_q;
	logic            out_valid_q;
	fcne_pkg::beat_t out_q;

	logic [7:0]      char_q;
	logic            end_q;
	logic [31:0]     off_q;
	logic [31:0]     size_q;
	logic            in_range_q;
	logic            prev_ok_q;
	logic [7:0]      bytes_q [BYTES_PER_RESULT];

	logic            accept;
	logic            out_free;
	logic            beat_load;
	logic            push;
	logic [7:0]      push_val;
	logic            chunk_done;
	logic [RW-1:0]   gather_sum;
	logic            ram_we;
	logic [IW:0]     ram_waddr;
	logic [IW:0]     ram_raddr;
	logic [7:0]      ram_rdata;
	logic [63:0]     name_word;
	logic [AW-1:0]   pad_len;
	logic [8:0]      phase_next;

	assign accept     = in_valid && (state_q == S_IDLE);
	assign busy       = (state_q != S_IDLE);
	assign out_free   = !out_valid_q || !out_stall;
	assign beat_load  = out_free && (state_q inside {S_ADDR, S_RST, S_EMIT, S_TOTAL});
	assign out_valid  = out_valid_q;
	assign out_beat   = out_q;
	assign pad_len    = AW'(0) - nsb_q[AW-1:0];
	assign phase_next = {1'b0, phase_q} + 9'd1;

	assign push = ((state_q == S_GATHER) && (pad_mode_q || (pos_q < RW'(2))))
		|| (state_q == S_WAIT);

	always_comb begin
		if (state_q == S_WAIT) begin
			push_val = ram_rdata;
		end else if (pad_mode_q) begin
			push_val = 8'd0;
		end else if (pos_q == '0) begin
			push_val = 8'(she_q);
		end else begin
			push_val = 8'(cur_len_q - she_q);
		end
	end

	assign chunk_done = push
		&& ((cnt_q == CW'(BYTES_PER_RESULT - 1)) || (pos_q == rec_len_q - RW'(1)));

	assign gather_sum = RW'(she_q) + pos_q - RW'(2);
	assign ram_we     = accept && !mode && (cur_len_q < LW'(MAX_NAME_LEN));
	assign ram_waddr  = {bank_q, cur_len_q[IW-1:0]};
	assign ram_raddr  = (state_q == S_IDLE) ? {~bank_q, cur_len_q[IW-1:0]}
		: {bank_q, gather_sum[IW-1:0]};

	always_comb begin
		name_word = '0;
		for (int j = 0; j < BYTES_PER_RESULT; j++) begin
			if (4'(j) < ecnt_q) begin
				name_word[j*8 +: 8] = bytes_q[j];
			end
		end
	end

	fcne_ram #(
		.WIDTH(8),
		.DEPTH(2 << IW)
	) u_name_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(name_char),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// captured item fields and chunk bytes
	always_ff @(posedge clk) begin
		if (accept) begin
			char_q     <= name_char;
			end_q      <= name_end;
			off_q      <= sym_offset;
			size_q     <= sym_size;
			in_range_q <= (cur_len_q < LW'(MAX_NAME_LEN));
			prev_ok_q  <= (cur_len_q < prev_len_q);
		end
		if (push) begin
			bytes_q[cnt_q] <= push_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			bank_q       <= 1'b0;
			cur_len_q    <= '0;
			prev_len_q   <= '0;
			shared_q     <= '0;
			match_q      <= 1'b1;
			ovf_q        <= 1'b0;
			sym_cnt_q    <= '0;
			nsb_q        <= '0;
			phase_q      <= '0;
			she_q        <= '0;
			rec_len_q    <= '0;
			pos_q        <= '0;
			cnt_q        <= '0;
			ecnt_q       <= '0;
			last_chunk_q <= 1'b0;
			pad_mode_q   <= 1'b0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			if (out_valid_q && !out_stall && !beat_load) begin
				out_valid_q <= 1'b0;
			end

			if (push) begin
				nsb_q <= nsb_q + 32'd1;
				pos_q <= pos_q + RW'(1);
				if (chunk_done) begin
					cnt_q        <= '0;
					ecnt_q       <= 4'(cnt_q) + 4'd1;
					last_chunk_q <= (pos_q == rec_len_q - RW'(1));
				end else begin
					cnt_q <= cnt_q + CW'(1);
				end
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (mode) begin
							pad_mode_q <= 1'b1;
							rec_len_q  <= RW'(pad_len);
							pos_q      <= '0;
							cnt_q      <= '0;
							state_q    <= (pad_len == '0) ? S_TOTAL : S_GATHER;
						end else begin
							state_q <= S_CMP;
						end
					end
				end
				S_CMP: begin
					if (in_range_q) begin
						cur_len_q <= cur_len_q + LW'(1);
						if (match_q && prev_ok_q && (ram_rdata == char_q)) begin
							shared_q <= shared_q + LW'(1);
						end else begin
							match_q <= 1'b0;
						end
					end else begin
						ovf_q <= 1'b1;
					end
					state_q <= end_q ? S_ADDR : S_IDLE;
				end
				S_ADDR: begin
					if (out_free) begin
						out_valid_q         <= 1'b1;
						out_q.kind          <= fcne_pkg::KIND_ADDR;
						out_q.payload       <= {size_q, off_q};
						out_q.byte_count    <= 4'd0;
						out_q.name_too_long <= ovf_q;
						out_q.run_last      <= 1'b0;
						pad_mode_q          <= 1'b0;
						pos_q               <= '0;
						cnt_q               <= '0;
						if (phase_q == 8'd0) begin
							she_q     <= '0;
							rec_len_q <= RW'(cur_len_q) + RW'(2);
							state_q   <= S_RST;
						end else begin
							she_q     <= shared_q;
							rec_len_q <= RW'(cur_len_q) - RW'(shared_q) + RW'(2);
							state_q   <= S_GATHER;
						end
					end
				end
				S_RST: begin
					if (out_free) begin
						out_valid_q         <= 1'b1;
						out_q.kind          <= fcne_pkg::KIND_RESTART;
						out_q.payload       <= {32'd0, nsb_q};
						out_q.byte_count    <= 4'd0;
						out_q.name_too_long <= ovf_q;
						out_q.run_last      <= 1'b0;
						state_q             <= S_GATHER;
					end
				end
				S_GATHER: begin
					if (push) begin
						if (chunk_done) begin
							state_q <= S_EMIT;
						end
					end else begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					state_q <= chunk_done ? S_EMIT : S_GATHER;
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q         <= 1'b1;
						out_q.kind          <= fcne_pkg::KIND_NAME;
						out_q.payload       <= name_word;
						out_q.byte_count    <= ecnt_q;
						out_q.name_too_long <= !pad_mode_q && ovf_q;
						out_q.run_last      <= last_chunk_q && !pad_mode_q;
						if (!last_chunk_q) begin
							state_q <= S_GATHER;
						end else if (pad_mode_q) begin
							state_q <= S_TOTAL;
						end else begin
							// name done: swap banks and move to the next symbol
							sym_cnt_q  <= sym_cnt_q + 32'd1;
							phase_q    <= (phase_next >= {1'b0, restart_every}) ? 8'd0
								: phase_next[7:0];
							bank_q     <= ~bank_q;
							prev_len_q <= cur_len_q;
							cur_len_q  <= '0;
							shared_q   <= '0;
							match_q    <= 1'b1;
							ovf_q      <= 1'b0;
							state_q    <= S_IDLE;
						end
					end
				end
				S_TOTAL: begin
					if (out_free) begin
						out_valid_q         <= 1'b1;
						out_q.kind          <= fcne_pkg::KIND_TOTAL;
						out_q.payload       <= {nsb_q, sym_cnt_q};
						out_q.byte_count    <= 4'd0;
						out_q.name_too_long <= 1'b0;
						out_q.run_last      <= 1'b1;
						cur_len_q           <= '0;
						prev_len_q          <= '0;
						shared_q            <= '0;
						match_q             <= 1'b1;
						ovf_q               <= 1'b0;
						sym_cnt_q           <= '0;
						nsb_q               <= '0;
						phase_q             <= '0;
						state_q             <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hdl/front_coded_name_encoder.sv =====
// front_coded_name_encoder: a name character is compared to the previous name; a closing
// character then emits the address beat, a restart beat at restart points, the header bytes,
// the suffix bytes and the name beats; end of table emits any pad bytes in name beats and
// then the totals beat; output stalls hold each beat, and suffix bytes come from registered
// name ram reads; reset clears all counters, restart interval returns to 16
// name ram contents are not cleared; depends on fcne_pkg and fcne_seq
module front_coded_name_encoder #(
	parameter int MAX_NAME_LEN     = fcne_pkg::DEF_MAX_NAME_LEN,
	parameter int BYTES_PER_RESULT = fcne_pkg::DEF_BYTES_PER_RESULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fcne_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            mode,
	input  logic [7:0]                      name_char,
	input  logic                            name_end,
	input  logic [31:0]                     sym_offset,
	input  logic [31:0]                     sym_size,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      kind,
	output logic [63:0]                     payload,
	output logic [3:0]                      byte_count,
	output logic                            name_too_long,
	output logic                            run_last
);

	logic [7:0]      restart_every_q;
	fcne_pkg::beat_t beat;

	assign pready = 1'b1;
	assign prdata = (paddr == fcne_pkg::REG_RESTART_EVERY) ? {24'd0, restart_every_q}
		: 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_every_q <= fcne_pkg::DEF_RESTART_EVERY;
		end else if (psel && penable && pwrite && pready
			&& (paddr == fcne_pkg::REG_RESTART_EVERY)) begin
			restart_every_q <= pwdata[7:0];
		end
	end

	fcne_seq #(
		.MAX_NAME_LEN    (MAX_NAME_LEN),
		.BYTES_PER_RESULT(BYTES_PER_RESULT)
	) u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.restart_every   (restart_every_q),
		.in_valid        (in_valid),
		.busy            (in_stall),
		.mode            (mode),
		.name_char       (name_char),
		.name_end        (name_end),
		.sym_offset      (sym_offset),
		.sym_size        (sym_size),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_beat        (beat)
	);

	assign kind          = beat.kind;
	assign payload       = beat.payload;
	assign byte_count    = beat.byte_count;
	assign name_too_long = beat.name_too_long;
	assign run_last      = beat.run_last;

`ifndef SYNTHESIS
	a_total_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind == fcne_pkg::KIND_TOTAL)) |-> (run_last && !name_too_long))
		else $error("totals beat without run_last");

	a_name_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind == fcne_pkg::KIND_NAME)) |->
		((byte_count != 4'd0) && (byte_count <= 4'(BYTES_PER_RESULT))))
		else $error("name beat byte count out of range");

	a_other_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind != fcne_pkg::KIND_NAME)) |-> (byte_count == 4'd0))
		else $error("byte count on a non-name beat");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && run_last && !out_stall) |=> !out_valid)
		else $error("beat follows last beat without a new item");
`endif

endmodule

// ===== test/tb_top.sv =====
// tb_top: self-checking bench for front_coded_name_encoder, driving names, end of table
// beats and restart interval writes, with an in-bench front coder predicting every result beat
// depends on fcne_pkg and front_coded_name_encoder
module tb_top;
	import fcne_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int NAME_BUDGET = 12;

	class front_code_board;
		beat_t       beats_due[$];
		int          errors;
		logic [7:0]  interval;
		logic [7:0]  cur_name[DEF_MAX_NAME_LEN];
		logic [7:0]  prev_name[DEF_MAX_NAME_LEN];
		int unsigned cur_len;
		int unsigned prev_len;
		int unsigned shared_len;
		logic        matching;
		logic [31:0] sym_count;
		logic [31:0] section_bytes;
		int unsigned phase;
		logic        overflow;

		function new();
			errors = 0;
			interval = DEF_RESTART_EVERY;
			clear_table();
		endfunction

		function void clear_table();
			cur_len = 0;
			prev_len = 0;
			shared_len = 0;
			matching = 1'b1;
			sym_count = '0;
			section_bytes = '0;
			phase = 0;
			overflow = 1'b0;
		endfunction

		function void queue_beat(kind_t k, logic [63:0] p, logic [3:0] n, logic flag);
			beat_t b;
			b.kind = k;
			b.payload = p;
			b.byte_count = n;
			b.name_too_long = flag;
			b.run_last = 1'b0;
			beats_due.push_back(b);
		endfunction

		function void queue_bytes(logic [7:0] rec[$], logic flag);
			int unsigned pos;
			int unsigned take;
			logic [63:0] word;
			pos = 0;
			while (pos < rec.size()) begin
				take = rec.size() - pos;
				if (take > DEF_BYTES_PER_RESULT)
					take = DEF_BYTES_PER_RESULT;
				word = '0;
				for (int j = 0; j < take; j++)
					word |= 64'(rec[pos + j]) << (8 * j);
				queue_beat(KIND_NAME, word, 4'(take), flag);
				pos += take;
			end
		endfunction

		function void note_input(logic m, logic [7:0] c, logic e, logic [31:0] off,
				logic [31:0] sz);
			int          first;
			int unsigned pad;
			int unsigned shared;
			int unsigned suffix;
			logic        flag;
			logic [7:0]  rec[$];
			beat_t       b;
			first = beats_due.size();
			if (m) begin
				pad = (NAME_ALIGN - section_bytes % NAME_ALIGN) % NAME_ALIGN;
				for (int k = 0; k < pad; k++)
					rec.push_back(8'h00);
				queue_bytes(rec, 1'b0);
				section_bytes += pad;
				queue_beat(KIND_TOTAL, {section_bytes, sym_count}, 4'd0, 1'b0);
				clear_table();
			end else begin
				if (cur_len < DEF_MAX_NAME_LEN) begin
					cur_name[cur_len] = c;
					if (matching && cur_len < prev_len && prev_name[cur_len] == c)
						shared_len++;
					else
						matching = 1'b0;
					cur_len++;
				end else begin
					overflow = 1'b1;
				end
				if (e) begin
					flag = overflow;
					queue_beat(KIND_ADDR, {sz, off}, 4'd0, flag);
					if (phase == 0) begin
						queue_beat(KIND_RESTART, 64'(section_bytes), 4'd0, flag);
						shared = 0;
					end else begin
						shared = shared_len;
					end
					suffix = cur_len - shared;
					rec.push_back(8'(shared));
					rec.push_back(8'(suffix));
					for (int k = 0; k < suffix; k++)
						rec.push_back(cur_name[shared + k]);
					queue_bytes(rec, flag);
					section_bytes += 2 + suffix;
					sym_count++;
					if (phase + 1 >= interval)
						phase = 0;
					else
						phase++;
					for (int k = 0; k < cur_len; k++)
						prev_name[k] = cur_name[k];
					prev_len = cur_len;
					cur_len = 0;
					shared_len = 0;
					matching = 1'b1;
					overflow = 1'b0;
				end
			end
			if (beats_due.size() > first) begin
				b = beats_due[beats_due.size() - 1];
				b.run_last = 1'b1;
				beats_due[beats_due.size() - 1] = b;
			end
		endfunction

		function void complain(string field, logic [63:0] want, logic [63:0] got);
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
		endfunction

		function void check_beat(beat_t got);
			beat_t want;
			if (beats_due.size() == 0) begin
				complain("unexpected beat", '0, got.payload);
				return;
			end
			want = beats_due.pop_front();
			if (got.kind != want.kind)
				complain("kind", 64'(want.kind), 64'(got.kind));
			if (got.payload != want.payload)
				complain("payload", want.payload, got.payload);
			if (got.byte_count != want.byte_count)
				complain("byte_count", 64'(want.byte_count), 64'(got.byte_count));
			if (got.name_too_long != want.name_too_long)
				complain("name_too_long", 64'(want.name_too_long), 64'(got.name_too_long));
			if (got.run_last != want.run_last)
				complain("run_last", 64'(want.run_last), 64'(got.run_last));
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;
	logic                  in_valid;
	logic                  in_stall;
	logic                  mode;
	logic [7:0]            name_char;
	logic                  name_end;
	logic [31:0]           sym_offset;
	logic [31:0]           sym_size;
	logic                  out_valid;
	logic                  out_stall;
	logic [1:0]            kind;
	logic [63:0]           payload;
	logic [3:0]            byte_count;
	logic                  name_too_long;
	logic                  run_last;

	front_code_board board;
	logic [7:0]      last_name[$];
	logic            send_calm;
	int              cycles;

	front_coded_name_encoder u_top (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			board.check_beat(beat_t'({kind, payload, byte_count, name_too_long, run_last}));

	initial begin
		int hold;
		out_stall = 1'b0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
			end else if (out_stall || $urandom_range(0, 2) != 0) begin
				out_stall <= 1'b0;
				hold = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
					: $urandom_range(0, 8);
			end else begin
				out_stall <= 1'b1;
				hold = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
					: $urandom_range(0, 3);
			end
		end
	end

	function automatic logic [7:0] rand_char();
		return ($urandom_range(0, 29) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
	endfunction

	task automatic send_item(logic m, logic [7:0] c, logic e, logic [31:0] off,
			logic [31:0] sz);
		int gap;
		if ($urandom_range(0, 39) == 0)
			send_calm = ~send_calm;
		gap = 0;
		if (!send_calm) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: gap = 0;
				9: gap = $urandom_range(8, 30);
				default: gap = $urandom_range(1, 3);
			endcase
		end
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		mode <= m;
		name_char <= c;
		name_end <= e;
		sym_offset <= off;
		sym_size <= sz;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_input(m, c, e, off, sz);
	endtask

	task automatic send_name(logic [7:0] chars[$], logic [31:0] off, logic [31:0] sz);
		for (int i = 0; i < chars.size(); i++) begin
			if (i == chars.size() - 1)
				send_item(1'b0, chars[i], 1'b1, off, sz);
			else
				send_item(1'b0, chars[i], 1'b0, $urandom, $urandom);
		end
		last_name = chars;
	endtask

	task automatic send_random_name(int len);
		logic [7:0] chars[$];
		int         share;
		share = (last_name.size() < len) ? last_name.size() : len;
		share = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(0, share);
		for (int i = 0; i < len; i++)
			chars.push_back((i < share) ? last_name[i] : rand_char());
		send_name(chars, $urandom, $urandom);
	endtask

	task automatic send_table_end();
		send_item(1'b1, 8'($urandom), 1'($urandom), $urandom, $urandom);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.beats_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic apb_access(logic wr, logic [7:0] wdata, output logic [31:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= REG_RESTART_EVERY;
		pwdata <= {24'h0, wdata};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_interval(logic [7:0] want);
		logic [31:0] rdata;
		apb_access(1'b0, 8'h00, rdata);
		if (rdata[7:0] !== want)
			board.complain("restart_every readback", 64'(want), 64'(rdata));
	endtask

	task automatic set_interval(logic [7:0] v);
		logic [31:0] rdata;
		wait_idle();
		apb_access(1'b1, v, rdata);
		board.interval = v;
		check_interval(v);
	endtask

	task automatic random_phase(int budget);
		int  count;
		int  r;
		int  len;
		count = 0;
		while (count < budget) begin
			r = $urandom_range(0, 99);
			if (r < 5) begin
				send_table_end();
				count++;
			end else if (r < 8) begin
				len = $urandom_range(1, 6);
				repeat (len) send_item(1'b0, rand_char(), 1'b0, $urandom, $urandom);
				send_table_end();
				count += len + 1;
			end else begin
				r = $urandom_range(0, 99);
				len = (r < 70) ? $urandom_range(1, 10)
					: (r < 95) ? $urandom_range(11, 40) : $urandom_range(41, 90);
				send_random_name(len);
				count += len;
			end
		end
	endtask

	initial begin
		logic [7:0] intervals[6];
		logic [7:0] long_name[$];

		board = new();
		send_calm = 1'b0;
		cycles = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		mode = 1'b0;
		name_char = 8'h00;
		name_end = 1'b0;
		sym_offset = '0;
		sym_size = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty table, field extremes, shared prefixes, zero bytes
		check_interval(DEF_RESTART_EVERY);
		send_item(1'b1, 8'hFF, 1'b1, 32'h0, 32'h0);
		send_name('{8'h41}, 32'h0, 32'h0);
		send_name('{8'h41, 8'h00, 8'hFF}, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_name('{8'h41, 8'h00, 8'h80, 8'h7F}, 32'h1234_5678, 32'h0);
		send_name('{8'h41, 8'h00, 8'h80, 8'h7F}, 32'h0, 32'h8000_0001);
		send_name('{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40},
			32'hA5A5_5A5A, 32'h5A5A_A5A5);
		// unfinished name dropped by end of table
		send_item(1'b0, 8'h55, 1'b0, 32'h0, 32'h0);
		send_item(1'b0, 8'hAA, 1'b0, 32'h0, 32'h0);
		send_item(1'b1, 8'h00, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		intervals = '{8'd1, 8'd255, 8'd0, 8'd3, 8'($urandom_range(2, 20)), 8'd16};
		for (int p = 0; p < 6; p++) begin
			set_interval(intervals[p]);
			if (p == 1) begin
				// short name, then a name cut past the limit that starts with it
				long_name.delete();
				for (int i = 0; i < 20; i++)
					long_name.push_back(8'($urandom_range(1, 255)));
				send_name(long_name, $urandom, $urandom);
				for (int i = 20; i < DEF_MAX_NAME_LEN + 3; i++)
					long_name.push_back(rand_char());
				send_name(long_name, $urandom, $urandom);
			end
			random_phase(NAME_BUDGET);
		end
		send_table_end();

		@(negedge clk);
		in_valid <= 1'b0;
		while (board.beats_due.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		if (board.errors == 0 && board.beats_due.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== front_coded_name_encoder.f =====
hdl/fcne_pkg.sv
hdl/fcne_ram.sv
hdl/fcne_seq.sv
hdl/front_coded_name_encoder.sv
test/tb_top.sv
